[hdl/pwc_pkg.sv]
// Shared types, codes and helpers for the provisioning window controller.
package pwc_pkg;

	localparam int unsigned TimeW = 32;
	localparam int unsigned FailW = 8;
	localparam int unsigned QueueDepth = 2;
	localparam int unsigned AddrW = 4;

	localparam logic [FailW-1:0] FailMax = 8'hFF;

	localparam logic [TimeW-1:0] ConfirmTimeoutRst = 32'd3000;
	localparam logic [TimeW-1:0] WindowTimeoutRst = 32'd300000;
	localparam logic [FailW-1:0] FailureLimitRst = 8'd5;

	// register index = paddr[3:2]
	localparam logic [1:0] RegConfirmTimeout = 2'd0;
	localparam logic [1:0] RegWindowTimeout = 2'd1;
	localparam logic [1:0] RegFailureLimit = 2'd2;

	typedef enum logic [2:0] {
		CMD_TICK = 3'd0,
		CMD_NET_RESET = 3'd1,
		CMD_FACTORY_RESET = 3'd2,
		CMD_PRESS = 3'd3,
		CMD_CREDS = 3'd4,
		CMD_CONN_OK = 3'd5,
		CMD_CONN_FAIL = 3'd6,
		CMD_INIT = 3'd7
	} cmd_t;

	localparam logic [1:0] ModeCodeProv = 2'd0;
	localparam logic [1:0] ModeCodeConn = 2'd1;
	localparam logic [1:0] ModeCodeOnline = 2'd2;

	typedef enum logic [2:0] {
		M_PROV = 3'b001,
		M_CONN = 3'b010,
		M_ONLINE = 3'b100
	} mode_t;

	// classified event, one-hot in its kind fields
	typedef struct packed {
		logic is_tick;
		logic is_wipe;
		logic is_press;
		logic is_creds;
		logic is_ok;
		logic is_fail;
		logic is_init;
		logic [TimeW-1:0] now;
		logic has_creds;
		logic recovery;
	} event_t;

	typedef struct packed {
		logic [TimeW-1:0] confirm_timeout;
		logic [TimeW-1:0] window_timeout;
		logic [FailW-1:0] failure_limit;
	} cfg_t;

	function automatic logic [1:0] mode_code(input mode_t m);
		logic [1:0] c;
		begin
			case (m)
				M_PROV: c = ModeCodeProv;
				M_ONLINE: c = ModeCodeOnline;
				default: c = ModeCodeConn;
			endcase
			return c;
		end
	endfunction

endpackage

[hdl/pwc_front.sv]
// Front part: accepts items, classifies the command and queues the events.
module pwc_front (
	input logic clk,
	input logic arst_n,
	input logic valid,
	output logic ready,
	input logic [2:0] cmd,
	input logic [pwc_pkg::TimeW-1:0] now_ms,
	input logic init_has_credentials,
	input logic init_recovery,
	output logic ev_valid,
	output pwc_pkg::event_t ev,
	input logic ev_pop
);

	pwc_pkg::event_t ev_new;
	pwc_pkg::event_t fifo_q [pwc_pkg::QueueDepth];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	logic push;

	always_comb begin
		ev_new = '0;
		ev_new.now = now_ms;
		ev_new.has_creds = init_has_credentials;
		ev_new.recovery = init_recovery;
		case (pwc_pkg::cmd_t'(cmd))
			pwc_pkg::CMD_NET_RESET, pwc_pkg::CMD_FACTORY_RESET: ev_new.is_wipe = 1'b1;
			pwc_pkg::CMD_PRESS: ev_new.is_press = 1'b1;
			pwc_pkg::CMD_CREDS: ev_new.is_creds = 1'b1;
			pwc_pkg::CMD_CONN_OK: ev_new.is_ok = 1'b1;
			pwc_pkg::CMD_CONN_FAIL: ev_new.is_fail = 1'b1;
			pwc_pkg::CMD_INIT: ev_new.is_init = 1'b1;
			default: ev_new.is_tick = 1'b1;
		endcase
	end

	assign ready = (count_q != 2'(pwc_pkg::QueueDepth));
	assign push = valid && ready;
	assign ev_valid = (count_q != 2'd0);
	assign ev = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= ev_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (ev_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, ev_pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[hdl/pwc_back.sv]
// Back part: controller state update and the result register.
module pwc_back (
	input logic clk,
	input logic arst_n,
	input pwc_pkg::cfg_t cfg,
	input logic ev_valid,
	input pwc_pkg::event_t ev,
	output logic ev_pop,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] mode,
	output logic radios_active,
	output logic ble_releasable,
	output logic confirm_waiting,
	output logic window_is_bounded,
	output logic credentials_held,
	output logic [pwc_pkg::FailW-1:0] failure_count
);

	pwc_pkg::mode_t mode_q, mode_n;
	logic radios_q, radios_n;
	logic bounded_q, bounded_n;
	logic [pwc_pkg::TimeW-1:0] wstart_q, wstart_n;
	logic creds_q, creds_n;
	logic [pwc_pkg::FailW-1:0] fail_q, fail_n, fail_inc;
	logic armed_q, armed_n;
	logic [pwc_pkg::TimeW-1:0] arm_start_q, arm_start_n;
	logic arm_now;
	logic [pwc_pkg::TimeW-1:0] arm_age;
	logic [pwc_pkg::TimeW-1:0] win_age;
	logic arm_live;
	logic pending_n;
	logic out_valid_q;
	logic [1:0] mode_out_q;
	logic radios_out_q;
	logic confirm_out_q;
	logic bounded_out_q;
	logic creds_out_q;
	logic [pwc_pkg::FailW-1:0] fail_out_q;

	assign ev_pop = ev_valid && (!out_valid_q || out_ready);

	// ages wrap modulo 2^32
	assign arm_age = ev.now - arm_start_q;
	assign win_age = ev.now - wstart_q;
	assign arm_live = armed_q && (arm_age < cfg.confirm_timeout);
	assign fail_inc = (fail_q < pwc_pkg::FailMax) ? fail_q + 8'd1 : fail_q;

	always_comb begin
		mode_n = mode_q;
		radios_n = radios_q;
		bounded_n = bounded_q;
		wstart_n = wstart_q;
		creds_n = creds_q;
		fail_n = fail_q;
		armed_n = armed_q;
		arm_start_n = arm_start_q;
		arm_now = 1'b0;
		if (ev.is_init) begin
			creds_n = ev.has_creds;
			fail_n = '0;
			armed_n = 1'b0;
			arm_start_n = ev.now;
			arm_now = 1'b1;
			wstart_n = ev.now;
			bounded_n = 1'b0;
			if (ev.recovery || !ev.has_creds) begin
				mode_n = pwc_pkg::M_PROV;
				radios_n = 1'b1;
				bounded_n = ev.has_creds;
			end else begin
				mode_n = pwc_pkg::M_CONN;
				radios_n = 1'b0;
			end
		end else if (ev.is_wipe) begin
			creds_n = 1'b0;
			fail_n = '0;
			mode_n = pwc_pkg::M_PROV;
			radios_n = 1'b1;
			bounded_n = 1'b0;
			wstart_n = ev.now;
			armed_n = 1'b0;
		end else if (ev.is_press) begin
			if (mode_q == pwc_pkg::M_PROV) begin
				if (bounded_q) begin
					wstart_n = ev.now;
				end
			end else if (mode_q == pwc_pkg::M_ONLINE && !arm_live) begin
				armed_n = 1'b1;
				arm_start_n = ev.now;
				arm_now = 1'b1;
			end else begin
				mode_n = pwc_pkg::M_PROV;
				radios_n = 1'b1;
				bounded_n = 1'b1;
				wstart_n = ev.now;
				armed_n = 1'b0;
			end
		end else if (ev.is_creds) begin
			armed_n = 1'b0;
			creds_n = 1'b1;
			fail_n = '0;
			mode_n = pwc_pkg::M_CONN;
		end else if (ev.is_ok) begin
			armed_n = 1'b0;
			mode_n = pwc_pkg::M_ONLINE;
			radios_n = 1'b0;
			bounded_n = 1'b0;
			fail_n = '0;
		end else if (ev.is_fail) begin
			armed_n = 1'b0;
			fail_n = fail_inc;
			if (radios_q) begin
				// back to provisioning, window kept as it was
				mode_n = pwc_pkg::M_PROV;
			end else if (fail_inc >= cfg.failure_limit) begin
				mode_n = pwc_pkg::M_PROV;
				radios_n = 1'b1;
				bounded_n = 1'b0;
				wstart_n = ev.now;
			end else begin
				mode_n = pwc_pkg::M_CONN;
			end
		end else if (ev.is_tick) begin
			if (armed_q && !(arm_age < cfg.confirm_timeout)) begin
				armed_n = 1'b0;
			end
			if (mode_q == pwc_pkg::M_PROV && bounded_q &&
				!(win_age < cfg.window_timeout)) begin
				mode_n = pwc_pkg::M_CONN;
				radios_n = 1'b0;
				bounded_n = 1'b0;
			end
		end
		// a fresh arm has age zero
		pending_n = armed_n && (arm_now ? (cfg.confirm_timeout != '0) :
			(arm_age < cfg.confirm_timeout));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= pwc_pkg::M_PROV;
			radios_q <= 1'b1;
			bounded_q <= 1'b0;
			wstart_q <= '0;
			creds_q <= 1'b0;
			fail_q <= '0;
			armed_q <= 1'b0;
			arm_start_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ev_pop) begin
				mode_q <= mode_n;
				radios_q <= radios_n;
				bounded_q <= bounded_n;
				wstart_q <= wstart_n;
				creds_q <= creds_n;
				fail_q <= fail_n;
				armed_q <= armed_n;
				arm_start_q <= arm_start_n;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ev_pop) begin
			mode_out_q <= pwc_pkg::mode_code(mode_n);
			radios_out_q <= radios_n;
			confirm_out_q <= pending_n;
			bounded_out_q <= bounded_n;
			creds_out_q <= creds_n;
			fail_out_q <= fail_n;
		end
	end

	assign out_valid = out_valid_q;
	assign mode = mode_out_q;
	assign radios_active = radios_out_q;
	assign ble_releasable = ~radios_out_q;
	assign confirm_waiting = confirm_out_q;
	assign window_is_bounded = bounded_out_q;
	assign credentials_held = creds_out_q;
	assign failure_count = fail_out_q;

endmodule

[hdl/provisioning_window_controller_unit.sv]
// Top level: input channel, register port, front queue and back state unit.
// Provisioning window controller.
// Input channel (valid/ready): one event per item, cmd plus now_ms and the
// init flags. Output channel (out_valid/out_ready): one result per event,
// in order, with the mode and flags as they stand after that event.
// An accepted item is written into the event queue; the back unit pops it and registers its result.
// Throughput: one item per cycle while the receiver keeps up; the back unit does two 32-bit wrapping
// subtracts and compares per event combinationally.
// A two-entry event queue separates the front from the back, so the input
// keeps accepting while a result waits in the output register. When the
// receiver stalls, the output register holds, the queue fills and ready
// drops once two events are waiting.
// Registers over the APB port: 0x0 confirm_timeout_ms, 0x4 window_timeout_ms,
// 0x8 failure_limit; write them only while the block is idle.
// Reset (arst_n low) puts the block in unbounded provisioning, radios open,
// no credentials, no failures, gate disarmed, registers at their defaults;
// queue and output register empty.
module provisioning_window_controller_unit (
	input logic clk,
	input logic arst_n,
	input logic valid,
	output logic ready,
	input logic [2:0] cmd,
	input logic [31:0] now_ms,
	input logic init_has_credentials,
	input logic init_recovery,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] mode,
	output logic radios_active,
	output logic ble_releasable,
	output logic confirm_waiting,
	output logic window_is_bounded,
	output logic credentials_held,
	output logic [7:0] failure_count,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [pwc_pkg::AddrW-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	pwc_pkg::cfg_t cfg_q;
	pwc_pkg::event_t ev;
	logic ev_valid;
	logic ev_pop;
	logic wr_en;
	logic [1:0] reg_idx;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.confirm_timeout <= pwc_pkg::ConfirmTimeoutRst;
			cfg_q.window_timeout <= pwc_pkg::WindowTimeoutRst;
			cfg_q.failure_limit <= pwc_pkg::FailureLimitRst;
		end else if (wr_en) begin
			case (reg_idx)
				pwc_pkg::RegConfirmTimeout: cfg_q.confirm_timeout <= pwdata;
				pwc_pkg::RegWindowTimeout: cfg_q.window_timeout <= pwdata;
				pwc_pkg::RegFailureLimit: cfg_q.failure_limit <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			pwc_pkg::RegConfirmTimeout: prdata = cfg_q.confirm_timeout;
			pwc_pkg::RegWindowTimeout: prdata = cfg_q.window_timeout;
			pwc_pkg::RegFailureLimit: prdata = {24'd0, cfg_q.failure_limit};
			default: prdata = '0;
		endcase
	end

	pwc_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.valid(valid),
		.ready(ready),
		.cmd(cmd),
		.now_ms(now_ms),
		.init_has_credentials(init_has_credentials),
		.init_recovery(init_recovery),
		.ev_valid(ev_valid),
		.ev(ev),
		.ev_pop(ev_pop)
	);

	pwc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.ev_valid(ev_valid),
		.ev(ev),
		.ev_pop(ev_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.mode(mode),
		.radios_active(radios_active),
		.ble_releasable(ble_releasable),
		.confirm_waiting(confirm_waiting),
		.window_is_bounded(window_is_bounded),
		.credentials_held(credentials_held),
		.failure_count(failure_count)
	);

`ifndef NO_ASSERTIONS
	// a bounded window only exists while the radios are open
	a_bounded_radios: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && window_is_bounded |-> radios_active)
		else $error("bounded window reported with radios closed");

	// the confirmation gate is only armed while online
	a_confirm_online: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && confirm_waiting |-> mode == pwc_pkg::ModeCodeOnline)
		else $error("confirm pending outside online mode");

	// a stalled result does not move while new items keep arriving
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready && valid && ready |=>
			$stable(failure_count) && $stable(mode))
		else $error("result changed while stalled");
`endif

endmodule

[sim/provisioning_window_controller_unit_test.sv]
`timescale 1ns / 1ps
// Testbench for the provisioning window controller: directed and random items vs a predictor.
module provisioning_window_controller_unit_test;
	import pwc_pkg::*;

	typedef struct packed {
		logic [1:0] mode;
		logic radios;
		logic releasable;
		logic confirm;
		logic bounded;
		logic creds;
		logic [7:0] fails;
	} status_t;

	logic clk;
	logic arst_n;
	logic valid;
	logic ready;
	logic [2:0] cmd;
	logic [31:0] now_ms;
	logic init_has_credentials;
	logic init_recovery;
	logic out_valid;
	logic out_ready;
	logic [1:0] mode;
	logic radios_active;
	logic ble_releasable;
	logic confirm_waiting;
	logic window_is_bounded;
	logic credentials_held;
	logic [7:0] failure_count;
	logic psel;
	logic penable;
	logic pwrite;
	logic [AddrW-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	provisioning_window_controller_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.valid(valid),
		.ready(ready),
		.cmd(cmd),
		.now_ms(now_ms),
		.init_has_credentials(init_has_credentials),
		.init_recovery(init_recovery),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.mode(mode),
		.radios_active(radios_active),
		.ble_releasable(ble_releasable),
		.confirm_waiting(confirm_waiting),
		.window_is_bounded(window_is_bounded),
		.credentials_held(credentials_held),
		.failure_count(failure_count),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// predicted controller state and its settings
	logic [1:0] ctl_mode;
	logic ctl_radios;
	logic ctl_bounded;
	logic [31:0] ctl_win_start;
	logic ctl_creds;
	logic [7:0] ctl_fails;
	logic ctl_armed;
	logic [31:0] ctl_arm_start;
	logic [31:0] cfg_confirm;
	logic [31:0] cfg_window;
	logic [7:0] cfg_flimit;

	status_t expected_status_q[$];
	int unsigned errors;
	int unsigned items_sent;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	logic [31:0] cur_ms;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(5_000_000);
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic logic gate_live(logic [31:0] t);
		logic [31:0] age;
		age = t - ctl_arm_start;
		return ctl_armed && (age < cfg_confirm);
	endfunction

	function automatic void open_window(logic bnd, logic [31:0] start);
		ctl_mode = ModeCodeProv;
		ctl_radios = 1'b1;
		ctl_bounded = bnd;
		ctl_win_start = start;
		ctl_armed = 1'b0;
	endfunction

	function automatic status_t step_controller(cmd_t c, logic [31:0] t, logic has, logic rec);
		status_t s;
		logic [31:0] age;
		case (c)
			CMD_INIT: begin
				ctl_creds = has;
				ctl_fails = '0;
				ctl_armed = 1'b0;
				ctl_arm_start = t;
				if (rec || !has) begin
					open_window(has, t);
				end else begin
					ctl_mode = ModeCodeConn;
					ctl_radios = 1'b0;
					ctl_bounded = 1'b0;
					ctl_win_start = t;
				end
			end
			CMD_NET_RESET, CMD_FACTORY_RESET: begin
				ctl_creds = 1'b0;
				ctl_fails = '0;
				open_window(1'b0, t);
			end
			CMD_PRESS: begin
				if (ctl_mode == ModeCodeProv) begin
					if (ctl_bounded)
						ctl_win_start = t;
				end else if (ctl_mode == ModeCodeOnline && !gate_live(t)) begin
					ctl_armed = 1'b1;
					ctl_arm_start = t;
				end else begin
					open_window(1'b1, t);
				end
			end
			CMD_CREDS: begin
				ctl_armed = 1'b0;
				ctl_creds = 1'b1;
				ctl_fails = '0;
				ctl_mode = ModeCodeConn;
			end
			CMD_CONN_OK: begin
				ctl_armed = 1'b0;
				ctl_mode = ModeCodeOnline;
				ctl_radios = 1'b0;
				ctl_bounded = 1'b0;
				ctl_fails = '0;
			end
			CMD_CONN_FAIL: begin
				ctl_armed = 1'b0;
				if (ctl_fails < FailMax)
					ctl_fails = ctl_fails + 8'd1;
				// with radios open the window survives as it was
				if (ctl_radios)
					open_window(ctl_bounded, ctl_win_start);
				else if (ctl_fails >= cfg_flimit)
					open_window(1'b0, t);
				else
					ctl_mode = ModeCodeConn;
			end
			default: begin
				age = t - ctl_arm_start;
				if (ctl_armed && age >= cfg_confirm)
					ctl_armed = 1'b0;
				age = t - ctl_win_start;
				if (ctl_mode == ModeCodeProv && ctl_bounded && age >= cfg_window) begin
					ctl_mode = ModeCodeConn;
					ctl_radios = 1'b0;
					ctl_bounded = 1'b0;
				end
			end
		endcase
		s.mode = ctl_mode;
		s.radios = ctl_radios;
		s.releasable = !ctl_radios;
		s.confirm = gate_live(t);
		s.bounded = ctl_bounded;
		s.creds = ctl_creds;
		s.fails = ctl_fails;
		return s;
	endfunction

	task automatic report_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			errors++;
			if (errors <= 10)
				$display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
		end
	endtask

	// result checker
	always @(posedge clk) begin
		status_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_status_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: result with no item outstanding", $realtime);
			end else begin
				want = expected_status_q.pop_front();
				report_field("mode", want.mode, mode);
				report_field("radios_active", want.radios, radios_active);
				report_field("ble_releasable", want.releasable, ble_releasable);
				report_field("confirm_waiting", want.confirm, confirm_waiting);
				report_field("window_is_bounded", want.bounded, window_is_bounded);
				report_field("credentials_held", want.creds, credentials_held);
				report_field("failure_count", want.fails, failure_count);
			end
		end
	end

	// receiver stalls
	initial begin
		out_ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	task automatic send_item(cmd_t c, logic [31:0] t, logic has, logic rec);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			valid = 1'b0;
			@(negedge clk);
		end
		valid = 1'b1;
		cmd = c;
		now_ms = t;
		init_has_credentials = has;
		init_recovery = rec;
		@(posedge clk);
		while (!ready)
			@(posedge clk);
		expected_status_q.push_back(step_controller(c, t, has, rec));
		items_sent++;
	endtask

	// time stamps stay, step forward, jump to a random value or land on or just before the arm and window deadlines
	function automatic logic [31:0] pick_now();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 35)
			cur_ms = cur_ms + $urandom_range(0, 40);
		else if (r < 50)
			cur_ms = ctl_arm_start + cfg_confirm - $urandom_range(0, 1);
		else if (r < 65)
			cur_ms = ctl_win_start + cfg_window - $urandom_range(0, 1);
		else if (r < 75)
			cur_ms = cur_ms + $urandom_range(0, 5000);
		else if (r < 85)
			cur_ms = $urandom;
		return cur_ms;
	endfunction

	task automatic send_cmd(cmd_t c);
		send_item(c, pick_now(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endtask

	task automatic send_init(logic has, logic rec);
		send_item(CMD_INIT, pick_now(), has, rec);
	endtask

	task automatic wait_results_done();
		@(negedge clk);
		valid = 1'b0;
		while (expected_status_q.size() != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		logic [31:0] mask;
		mask = (idx == RegFailureLimit) ? 32'h0000_00FF : 32'hFFFF_FFFF;
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (idx)
			RegConfirmTimeout: cfg_confirm = val;
			RegWindowTimeout: cfg_window = val;
			default: cfg_flimit = val[7:0];
		endcase
		// read it back
		@(negedge clk);
		penable = 1'b0;
		pwrite = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if ((prdata & mask) != (val & mask)) begin
			errors++;
			if (errors <= 10)
				$display("%0t: register %0d read %h, expected %h", $realtime, idx, prdata, val);
		end
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	task automatic set_timing(logic [31:0] confirm, logic [31:0] window, logic [7:0] flimit);
		wait_results_done();
		write_reg(RegConfirmTimeout, confirm);
		write_reg(RegWindowTimeout, window);
		write_reg(RegFailureLimit, {24'd0, flimit});
	endtask

	task automatic run_random(int unsigned count);
		int unsigned stop_at;
		int unsigned k;
		logic [2:0] pick;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			case ($urandom_range(0, 5))
				0: begin
					// online session with presses and ticks
					send_init(1'b1, 1'b0);
					send_cmd(CMD_CONN_OK);
					repeat ($urandom_range(1, 4))
						send_cmd(($urandom_range(0, 9) < 6) ? CMD_PRESS : CMD_TICK);
					repeat ($urandom_range(0, 3))
						send_cmd(CMD_TICK);
				end
				1: begin
					send_init(1'b1, 1'($urandom_range(0, 1)));
					k = (cfg_flimit < 11) ? cfg_flimit + 1 : 12;
					repeat ($urandom_range(1, k))
						send_cmd(CMD_CONN_FAIL);
					if ($urandom_range(0, 1))
						send_cmd(CMD_CONN_OK);
				end
				2: begin
					// confirmed window, refreshed, then left to expire
					send_init(1'b1, 1'b0);
					send_cmd(CMD_CONN_OK);
					send_cmd(CMD_PRESS);
					send_cmd(CMD_PRESS);
					repeat ($urandom_range(1, 5))
						send_cmd(($urandom_range(0, 3) == 0) ? CMD_PRESS : CMD_TICK);
				end
				3: begin
					send_cmd($urandom_range(0, 1) ? CMD_NET_RESET : CMD_FACTORY_RESET);
					send_cmd(CMD_PRESS);
					send_cmd(CMD_CREDS);
					send_cmd($urandom_range(0, 1) ? CMD_CONN_OK : CMD_CONN_FAIL);
					send_cmd(CMD_TICK);
				end
				default: begin
					repeat ($urandom_range(1, 6)) begin
						pick = 3'($urandom_range(0, 7));
						send_cmd(cmd_t'(pick));
					end
				end
			endcase
		end
	endtask

	task automatic test_directed_defaults();
		send_item(CMD_TICK, 32'd0, 1'b0, 1'b0);
		send_item(CMD_PRESS, 32'd10, 1'b1, 1'b1);
		send_item(CMD_INIT, 32'd1000, 1'b1, 1'b0);
		send_item(CMD_PRESS, 32'd1100, 1'b0, 1'b0);
		send_item(CMD_PRESS, 32'd1200, 1'b0, 1'b0);
		send_item(CMD_TICK, 32'd1200 + 32'd300000 - 32'd1, 1'b0, 1'b0);
		send_item(CMD_TICK, 32'd1200 + 32'd300000, 1'b0, 1'b0);
		send_item(CMD_CONN_OK, 32'd400000, 1'b0, 1'b0);
		send_item(CMD_PRESS, 32'd500000, 1'b0, 1'b0);
		send_item(CMD_PRESS, 32'd502999, 1'b0, 1'b0);
		send_item(CMD_CONN_FAIL, 32'd503000, 1'b0, 1'b0);
		send_item(CMD_CREDS, 32'd503100, 1'b0, 1'b0);
		for (int i = 0; i < 5; i++)
			send_item(CMD_CONN_FAIL, 32'd503200 + 32'(i), 1'b1, 1'b1);
		send_item(CMD_FACTORY_RESET, 32'hFFFF_FFF0, 1'b1, 1'b1);
		send_item(CMD_INIT, 32'hFFFF_FFF8, 1'b0, 1'b1);
		send_item(CMD_INIT, 32'hFFFF_FFFF, 1'b1, 1'b1);
		send_item(CMD_NET_RESET, 32'h0000_0005, 1'b0, 1'b0);
		send_item(CMD_INIT, 32'hFFFF_FF00, 1'b1, 1'b0);
		send_item(CMD_CONN_OK, 32'hFFFF_FF10, 1'b0, 1'b0);
		send_item(CMD_PRESS, 32'hFFFF_FF20, 1'b0, 1'b0);
		// arm age reaches the timeout across the wrap
		send_item(CMD_TICK, 32'hFFFF_FF20 + 32'd3000, 1'b0, 1'b0);
		send_item(CMD_PRESS, 32'hFFFF_FF20 + 32'd3001, 1'b0, 1'b0);
	endtask

	task automatic test_shortest_settings();
		set_timing(32'd1, 32'd1, 8'd1);
		run_random(250);
	endtask

	task automatic test_longest_settings();
		set_timing(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255);
		run_random(120);
		wait_results_done();
		run_random(130);
	endtask

	task automatic test_typical_settings();
		set_timing($urandom_range(2, 100), $urandom_range(50, 500), 8'($urandom_range(2, 8)));
		run_random(350);
	endtask

	task automatic test_failure_saturation();
		set_timing(32'd3000, 32'd300000, 8'd255);
		send_init(1'b1, 1'b0);
		repeat (260)
			send_cmd(CMD_CONN_FAIL);
	endtask

	task automatic test_default_values();
		set_timing(32'd3000, 32'd300000, 8'd5);
		run_random(250);
	endtask

	initial begin
		arst_n = 1'b0;
		valid = 1'b0;
		cmd = CMD_TICK;
		now_ms = '0;
		init_has_credentials = 1'b0;
		init_recovery = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		errors = 0;
		items_sent = 0;
		cur_ms = $urandom;
		cfg_confirm = 32'd3000;
		cfg_window = 32'd300000;
		cfg_flimit = 8'd5;
		ctl_mode = ModeCodeProv;
		ctl_radios = 1'b1;
		ctl_bounded = 1'b0;
		ctl_win_start = '0;
		ctl_creds = 1'b0;
		ctl_fails = '0;
		ctl_armed = 1'b0;
		ctl_arm_start = '0;
		send_idle_pct = 30;
		recv_idle_pct = 83;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_defaults();
		test_shortest_settings();
		send_idle_pct = 83;
		recv_idle_pct = 30;
		test_longest_settings();
		test_typical_settings();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_failure_saturation();
		test_default_values();

		wait_results_done();
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

[sim.f]
hdl/pwc_pkg.sv
hdl/pwc_front.sv
hdl/pwc_back.sv
hdl/provisioning_window_controller_unit.sv
sim/provisioning_window_controller_unit_test.sv
